### rtl/srcu_pkg.sv
// shared types and constants for the sensor reading conversion unit
// no dependencies; imported by sensor_reading_conversion_unit and the testbench
package srcu_pkg;

	// fixed arithmetic constants
	localparam logic signed [11:0] TEMP_OFFSET = 12'sd397;
	localparam logic [11:0] RH_KNEE = 12'd1712;

	// reciprocals for division by constants (multiply, then shift)
	localparam logic [15:0] RECIP10 = 16'd52429;     // /10, shift 19
	localparam logic [12:0] RECIP80 = 13'd6554;      // /80, shift 19
	localparam logic [16:0] RECIP102 = 17'd41121;    // /102, shift 22
	localparam logic [16:0] RECIP51 = 17'd82242;     // /51, shift 22
	localparam logic [7:0] RECIP10_SMALL = 8'd205;   // /10 for small values, shift 11
	localparam logic [10:0] RECIP100 = 11'd1311;     // /100, shift 17
	localparam logic [15:0] RECIP43 = 16'd48771;     // /43, shift 21

	// divider geometry
	localparam int A_NW = 10;
	localparam int A_DW = 7;
	localparam int B_NW = 17;
	localparam int B_DW = 9;
	localparam int C_NW = 15;
	localparam int C_DW = 12;

	// data carried alongside the log divider
	typedef struct packed {
		logic signed [11:0] temp;
		logic [6:0] rh;
		logic lsmall;
		logic [6:0] lgs;
		logic signed [7:0] xadd;
		logic [16:0] an;
		logic [8:0] dn;
		logic qneg;
	} side_a_t;

	// data carried alongside the temperature term divider
	typedef struct packed {
		logic signed [11:0] temp;
		logic [6:0] rh;
		logic [8:0] kmag;
		logic qneg;
	} side_b_t;

	// data carried alongside the final divider
	typedef struct packed {
		logic signed [11:0] temp;
		logic [6:0] rh;
		logic signed [10:0] k2;
	} side_c_t;

endpackage

### rtl/srcu_div.sv
// pipelined restoring unsigned divider, one quotient bit per stage
// standalone; side data travels with each request through the stages
module srcu_div #(
	parameter int NW = 10,
	parameter int DW = 7,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side,
	output logic          out_valid,
	output logic [NW-1:0] quo,
	output logic [SW-1:0] out_side
);

	logic          v_s   [NW+1];
	logic [NW-1:0] num_s [NW+1];
	logic [DW-1:0] den_s [NW+1];
	logic [DW-1:0] rem_s [NW+1];
	logic [NW-1:0] quo_s [NW+1];
	logic [SW-1:0] side_s[NW+1];

	// stage zero is the incoming request
	always_comb begin
		v_s[0] = in_valid;
		num_s[0] = num;
		den_s[0] = den;
		rem_s[0] = '0;
		quo_s[0] = '0;
		side_s[0] = side;
	end

	// one compare and subtract per stage
	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [DW:0] trial;
		logic        fits;

		always_comb begin
			trial = {rem_s[k], num_s[k][NW-1-k]};
			fits = (trial >= {1'b0, den_s[k]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			num_s[k+1] <= num_s[k];
			den_s[k+1] <= den_s[k];
			side_s[k+1] <= side_s[k];
			rem_s[k+1] <= fits ? DW'(trial - {1'b0, den_s[k]}) : DW'(trial);
			quo_s[k+1] <= {quo_s[k][NW-2:0], fits};
		end
	end

	assign out_valid = v_s[NW];
	assign quo = quo_s[NW];
	assign out_side = side_s[NW];

endmodule

### rtl/sensor_reading_conversion_unit.sv
// top level of the sensor reading conversion unit: temperature, humidity, dew point
// depends on srcu_pkg and srcu_div
//
// channel   | handshake        | payload
// request   | start / busy     | temperature_ticks, humidity_ticks
// result    | strobe           | temperature_tenths, humidity_percent, dew_point_value
//
// one request enters per cycle; busy is always low
// the pipeline is 12 arithmetic stages plus the three dividers (10, 17, 15 stages)
// the dew point chain of three dependent divisions sets the pipeline depth
// reset clears only the valid bits; results come one per request, in order, never held

module sensor_reading_conversion_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [13:0]        temperature_ticks,
	input  logic [11:0]        humidity_ticks,
	output logic               strobe,
	output logic signed [11:0] temperature_tenths,
	output logic [6:0]         humidity_percent,
	output logic signed [11:0] dew_point_value
);
	import srcu_pkg::*;

	assign busy = 1'b0;

	// stage 1: capture request
	logic        v_s1;
	logic [13:0] tt_s1;
	logic [11:0] th_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		tt_s1 <= temperature_ticks;
		th_s1 <= humidity_ticks;
	end

	// stage 2: temperature ticks to tenths, humidity fit numerator
	logic               v_s2;
	logic signed [11:0] temp_s2;
	logic [15:0]        hnum_s2;
	logic               hseg_s2;
	logic [29:0]        tprod;
	logic signed [11:0] temp_c;
	logic               seg_c;
	logic [16:0]        n36;
	logic [15:0]        hnum_c;

	always_comb begin
		tprod = 30'(tt_s1) * 30'(RECIP10);
		temp_c = $signed({1'b0, tprod[29:19]}) - TEMP_OFFSET;
		seg_c = (th_s1 < RH_KNEE);
		n36 = 17'(th_s1) * 17'd36;
		if (seg_c) begin
			hnum_c = (n36 >= 17'd2048) ? 16'(n36 - 17'd2048) : 16'd0;
		end else begin
			hnum_c = 16'(17'(th_s1) * 17'd14 + 17'd5790);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		temp_s2 <= temp_c;
		hnum_s2 <= hnum_c;
		hseg_s2 <= seg_c;
	end

	// stage 3: fit division and temperature over 80
	logic               v_s3;
	logic signed [11:0] temp_s3;
	logic [10:0]        rh0_s3;
	logic signed [5:0]  t80_s3;
	logic [16:0]        hrec;
	logic [32:0]        hprod;
	logic [10:0]        tabs3;
	logic [23:0]        p80;
	logic signed [5:0]  t80_c;

	always_comb begin
		hrec = hseg_s2 ? RECIP102 : RECIP51;
		hprod = 33'(hnum_s2) * 33'(hrec);
		tabs3 = temp_s2[11] ? 11'(-temp_s2) : 11'(temp_s2);
		p80 = 24'(tabs3) * 24'(RECIP80);
		t80_c = temp_s2[11] ? -$signed({1'b0, p80[23:19]}) : $signed({1'b0, p80[23:19]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		temp_s3 <= temp_s2;
		rh0_s3 <= hprod[32:22];
		t80_s3 <= t80_c;
	end

	// stage 4: round to percent, force 100 above 98
	logic               v_s4;
	logic signed [11:0] temp_s4;
	logic [6:0]         rh1_s4;
	logic signed [5:0]  t80_s4;
	logic [26:0]        rprod;
	logic [7:0]         rr;

	always_comb begin
		rprod = 27'(12'(rh0_s3) + 12'd5) * 27'(RECIP10);
		rr = rprod[26:19];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		temp_s4 <= temp_s3;
		rh1_s4 <= (rr > 8'd98) ? 7'd100 : rr[6:0];
		t80_s4 <= t80_s3;
	end

	// stage 5: compensation with saturation, temperature over 10
	logic               v_s5;
	logic signed [11:0] temp_s5;
	logic [6:0]         rh_s5;
	logic [6:0]         ttabs_s5;
	logic               ttneg_s5;
	logic signed [8:0]  hs;
	logic [6:0]         rh_c;
	logic [10:0]        tabs5;
	logic [26:0]        p10;

	always_comb begin
		hs = $signed({2'b0, rh1_s4}) + {{3{t80_s4[5]}}, t80_s4} - 9'sd3;
		if (hs < 9'sd0) begin
			rh_c = 7'd0;
		end else if (hs > 9'sd100) begin
			rh_c = 7'd100;
		end else begin
			rh_c = hs[6:0];
		end
		tabs5 = temp_s4[11] ? 11'(-temp_s4) : 11'(temp_s4);
		p10 = 27'(tabs5) * 27'(RECIP10);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		temp_s5 <= temp_s4;
		rh_s5 <= rh_c;
		ttabs_s5 <= p10[25:19];
		ttneg_s5 <= temp_s4[11];
	end

	// stage 6: log terms that depend only on humidity, temperature term operands
	logic               v_s6;
	side_a_t            sa_s6;
	logic [9:0]         x19;
	logic [16:0]        p19;
	logic [12:0]        x67;
	logic [23:0]        p67;
	logic signed [7:0]  xadd_c;
	logic               mid;

	always_comb begin
		x19 = 10'(rh_s5) * 10'd19;
		p19 = 17'(x19) * 17'(RECIP10_SMALL);
		x67 = 13'(rh_s5) * 13'd67;
		p67 = 24'(x67) * 24'(RECIP100);
		mid = (rh_s5 > 7'd51) && (rh_s5 < 7'd81);
		if (rh_s5 < 7'd31) begin
			xadd_c = $signed({2'b0, p19[16:11]}) - 8'sd4;
		end else begin
			xadd_c = $signed({1'b0, p67[23:17]}) + (mid ? 8'sd42 : 8'sd39);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		sa_s6.temp <= temp_s5;
		sa_s6.rh <= rh_s5;
		sa_s6.lsmall <= (rh_s5 < 7'd8);
		sa_s6.lgs <= (rh_s5 == 7'd1) ? 7'd0 : (rh_s5 * 7'd11 + 7'd11);
		sa_s6.xadd <= xadd_c;
		sa_s6.an <= 17'(ttabs_s5) * 17'd881;
		sa_s6.dn <= ttneg_s5 ? (9'd243 - 9'(ttabs_s5)) : (9'd243 + 9'(ttabs_s5));
		sa_s6.qneg <= ttneg_s5;
	end

	// divider a: 980 over humidity
	logic            va;
	logic [A_NW-1:0] qa;
	side_a_t         sa;

	srcu_div #(
		.NW(A_NW),
		.DW(A_DW),
		.SW($bits(side_a_t))
	) u_div_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s6),
		.num      (A_NW'(980)),
		.den      (sa_s6.rh),
		.side     (sa_s6),
		.out_valid(va),
		.quo      (qa),
		.out_side (sa)
	);

	// stage 7: finish the log approximation
	logic               v_s7;
	logic [7:0]         lg_s7;
	side_a_t            sa_s7;
	logic [9:0]         d980;
	logic [17:0]        plg;
	logic signed [8:0]  lgsum;
	logic [7:0]         lg_c;

	always_comb begin
		d980 = 10'd980 - qa;
		plg = 18'(d980) * 18'(RECIP10_SMALL);
		lgsum = $signed({2'b0, plg[17:11]}) + {sa.xadd[7], sa.xadd};
		if (sa.lsmall) begin
			lg_c = {1'b0, sa.lgs};
		end else if (lgsum > 9'sd200) begin
			lg_c = 8'd200;
		end else begin
			lg_c = lgsum[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else begin
			v_s7 <= va;
		end
	end

	always_ff @(posedge clk) begin
		lg_s7 <= lg_c;
		sa_s7 <= sa;
	end

	// stage 8: numerator of the division by 43, magnitude form
	logic        v_s8;
	logic [14:0] num43_s8;
	side_a_t     sa_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		num43_s8 <= 15'd20000 - 15'(lg_s7) * 15'd100;
		sa_s8 <= sa_s7;
	end

	// stage 9: divide by 43
	logic        v_s9;
	side_a_t     sa_s9;
	logic [8:0]  kmag_s9;
	side_b_t     sb_c;
	logic [30:0] p43;

	always_comb begin
		p43 = 31'(num43_s8) * 31'(RECIP43);
		sb_c.temp = sa_s9.temp;
		sb_c.rh = sa_s9.rh;
		sb_c.kmag = kmag_s9;
		sb_c.qneg = sa_s9.qneg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		kmag_s9 <= p43[29:21];
		sa_s9 <= sa_s8;
	end

	// divider b: temperature term 881*t over 243+t
	logic            vb;
	logic [B_NW-1:0] qb;
	side_b_t         sb;

	srcu_div #(
		.NW(B_NW),
		.DW(B_DW),
		.SW($bits(side_b_t))
	) u_div_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s9),
		.num      (sa_s9.an),
		.den      (sa_s9.dn),
		.side     (sb_c),
		.out_valid(vb),
		.quo      (qb),
		.out_side (sb)
	);

	// stage 10: combine log and temperature terms
	logic               v_s10;
	side_c_t            sc_s10;
	logic [11:0]        d_s10;
	logic signed [9:0]  qs;
	logic signed [10:0] k2_c;

	always_comb begin
		qs = sb.qneg ? -$signed({1'b0, qb[8:0]}) : $signed({1'b0, qb[8:0]});
		k2_c = $signed({qs, 1'b0}) - $signed({2'b0, sb.kmag});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else begin
			v_s10 <= vb;
		end
	end

	always_ff @(posedge clk) begin
		sc_s10.temp <= sb.temp;
		sc_s10.rh <= sb.rh;
		sc_s10.k2 <= k2_c;
		d_s10 <= 12'd1762 - {k2_c[10], k2_c};
	end

	// divider c: 24310 over 1762 - k
	logic            vc;
	logic [C_NW-1:0] qc;
	side_c_t         sc;

	srcu_div #(
		.NW(C_NW),
		.DW(C_DW),
		.SW($bits(side_c_t))
	) u_div_c (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s10),
		.num      (C_NW'(24310)),
		.den      (d_s10),
		.side     (sc_s10),
		.out_valid(vc),
		.quo      (qc),
		.out_side (sc)
	);

	// stage 11: product with k, sign and magnitude
	logic               v_s11;
	logic [13:0]        pabs_s11;
	logic               pneg_s11;
	logic signed [11:0] temp_s11;
	logic [6:0]         rh_s11;
	logic signed [16:0] pk;
	logic signed [16:0] pkabs;

	always_comb begin
		pk = 17'($signed({1'b0, qc[4:0]})) * 17'(sc.k2);
		pkabs = pk[16] ? -pk : pk;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else begin
			v_s11 <= vc;
		end
	end

	always_ff @(posedge clk) begin
		pabs_s11 <= pkabs[13:0];
		pneg_s11 <= pk[16];
		temp_s11 <= sc.temp;
		rh_s11 <= sc.rh;
	end

	// stage 12: round away from zero, divide by 10, result register
	logic        v_s12;
	logic [29:0] pdp;
	logic [10:0] mdp;

	always_comb begin
		pdp = 30'(pabs_s11 + 14'd51) * 30'(RECIP10);
		mdp = pdp[29:19];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
		end else begin
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		temperature_tenths <= temp_s11;
		humidity_percent <= rh_s11;
		dew_point_value <= pneg_s11 ? -$signed({1'b0, mdp}) : $signed({1'b0, mdp});
	end

	assign strobe = v_s12;

`ifndef SYNTH
	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_rh_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> humidity_percent <= 7'd100)
		else $error("humidity out of range");
	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (temperature_tenths >= -12'sd397 && temperature_tenths <= 12'sd1241))
		else $error("temperature out of range");
	a_dew_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (dew_point_value >= -12'sd1000 && dew_point_value <= 12'sd1500))
		else $error("dew point out of range");
`endif

endmodule

### bench/tb_sensor_reading_conversion_unit.sv
// testbench for the sensor reading conversion unit: directed and random requests
// checked field by field against an in-bench conversion predictor; depends on srcu_pkg and the rtl
module tb_sensor_reading_conversion_unit;
	import srcu_pkg::*;

	typedef struct {
		logic signed [11:0] temp_tenths;
		logic [6:0]         hum_pct;
		logic signed [11:0] dew_val;
	} reading_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [13:0]        temperature_ticks;
	logic [11:0]        humidity_ticks;
	logic               strobe;
	logic signed [11:0] temperature_tenths;
	logic [6:0]         humidity_percent;
	logic signed [11:0] dew_point_value;

	reading_t pending_readings[$];
	int       mismatch_count = 0;
	int       reading_count = 0;
	int       request_count = 0;
	int       sender_idle_pct = 0;

	sensor_reading_conversion_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.temperature_ticks(temperature_ticks), .humidity_ticks(humidity_ticks),
		.strobe(strobe), .temperature_tenths(temperature_tenths),
		.humidity_percent(humidity_percent), .dew_point_value(dew_point_value)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// expected conversion of one pair of raw readings
	function automatic reading_t convert_reading(int tk, int hk);
		reading_t r;
		int temp, rh, num, lg, k, q, tt;
		temp = tk / 10 - 397;
		if (hk < 1712) begin
			num = 36 * hk - 2048;
			if (num < 0) num = 0;
			rh = num / 102;
		end else begin
			rh = (14 * hk + 5790) / 51;
		end
		rh = (rh + 5) / 10;
		if (rh > 98) rh = 100;
		// temperature compensation, saturated
		rh = rh + (temp / 80 - 3);
		if (rh < 0) rh = 0;
		if (rh > 100) rh = 100;
		// piecewise 100*log10 approximation
		if (rh == 1) begin
			lg = 0;
		end else if (rh < 8) begin
			lg = 11 * rh + 11;
		end else begin
			lg = (980 - 980 / rh) / 10;
			if (rh < 31) lg += (19 * rh) / 10 - 4;
			else if (rh > 51 && rh < 81) lg += (67 * rh) / 100 + 42;
			else lg += (67 * rh) / 100 + 39;
			if (lg > 200) lg = 200;
		end
		// dew point chain
		k = (100 * lg - 20000) / 43;
		tt = temp / 10;
		q = (881 * tt) / (243 + tt);
		k += q * 2;
		q = 24310 / (1762 - k);
		q *= k;
		if (q < 0) q -= 51;
		else q += 51;
		r.temp_tenths = 12'(temp);
		r.hum_pct = 7'(rh);
		r.dew_val = 12'(q / 10);
		return r;
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		$display("mismatch on result %0d: %s got %0d expected %0d",
			reading_count, field, got, want);
		mismatch_count++;
	endtask

	// send one request, holding start until accepted; idle cycles drawn one at a time
	task automatic send_reading(int tk, int hk);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		temperature_ticks <= 14'(tk);
		humidity_ticks <= 12'(hk);
		do @(posedge clk); while (busy);
		pending_readings.push_back(convert_reading(tk, hk));
		request_count++;
	endtask

	// compare each strobed result with the oldest expectation
	always @(posedge clk) begin
		reading_t want;
		if (arst_n && strobe) begin
			if (pending_readings.size() == 0) begin
				$display("unexpected result with nothing pending");
				mismatch_count++;
			end else begin
				want = pending_readings.pop_front();
				if (temperature_tenths !== want.temp_tenths)
					report_mismatch("temperature_tenths", temperature_tenths, want.temp_tenths);
				if (humidity_percent !== want.hum_pct)
					report_mismatch("humidity_percent", humidity_percent, want.hum_pct);
				if (dew_point_value !== want.dew_val)
					report_mismatch("dew_point_value", dew_point_value, want.dew_val);
			end
			reading_count++;
		end
	end

	// field extremes, the humidity knee, the floored numerator, saturation and log branches
	task automatic test_directed();
		send_reading(0, 0);
		send_reading(16383, 4095);
		send_reading(0, 4095);
		send_reading(16383, 0);
		send_reading(4000, 56);
		send_reading(4000, 57);
		send_reading(4000, 1711);
		send_reading(4000, 1712);
		send_reading(4000, 3300);
		send_reading(4000, 3400);
		send_reading(3970, 330);
		send_reading(3970, 345);
		send_reading(3970, 400);
		send_reading(3970, 800);
		send_reading(3970, 1500);
		send_reading(3970, 2300);
		send_reading(3970, 2700);
		send_reading(9000, 1000);
		send_reading(12000, 2000);
		send_reading(1000, 3000);
		send_reading(8191, 2048);
		send_reading(10000, 100);
	endtask

	// random pairs: uniform over the fields and biased toward the low-humidity range
	task automatic test_random(int count);
		repeat (count) begin
			if ($urandom_range(3) == 0)
				send_reading($urandom_range(16383), $urandom_range(300, 1100));
			else
				send_reading($urandom_range(16383), $urandom_range(4095));
		end
	endtask

	initial begin
		int waited;
		arst_n = 1'b0;
		start = 1'b0;
		temperature_ticks = '0;
		humidity_ticks = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		sender_idle_pct = 13;
		test_directed();
		test_random(560);
		sender_idle_pct = 52;
		test_random(560);
		sender_idle_pct = 0;
		test_random(560);
		start <= 1'b0;
		// drain outstanding results
		waited = 0;
		while (pending_readings.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (60) @(posedge clk);
		$display("sent %0d requests over three idling phases, checked %0d results",
			request_count, reading_count);
		if (mismatch_count == 0 && pending_readings.size() == 0) begin
			$display("sensor_reading_conversion_unit verification clean");
		end else begin
			$display("sensor_reading_conversion_unit verification failed");
		end
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("sensor_reading_conversion_unit verification failed");
		$finish;
	end
endmodule
